// ----- rtl/core/cmrt_pkg.sv -----
// Shared constants and types for the chunked message reassembly table.
`timescale 1ns / 1ps
package cmrt_pkg;

	localparam int TABLE_SLOTS_DEF = 8;
	localparam int MAX_CHUNKS_DEF  = 64;
	localparam int MAX_BYTES_DEF   = 512;
	localparam int BEAT_BYTES_DEF  = 8;

	localparam int RESULT_CAP = 64;
	localparam int MAP_W      = 64;
	localparam int WORD_BYTES = 8;
	localparam int WORD_W     = 64;
	localparam int PCT_MAX    = 99;
	localparam int PCT_FULL   = 100;
	localparam int CNT_MAX    = 127;

	typedef enum logic [1:0] {
		CMD_BEAT  = 2'd0,
		CMD_QUERY = 2'd1,
		CMD_DRAIN = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_OK      = 4'd0,
		ST_DUP     = 4'd1,
		ST_BAD     = 4'd2,
		ST_OOB     = 4'd3,
		ST_FULL    = 4'd4,
		ST_PERCENT = 4'd5,
		ST_DATA    = 4'd6,
		ST_NONE    = 4'd7,
		ST_CLEARED = 4'd8
	} status_t;

endpackage

// ----- rtl/core/cmrt_ram.sv -----
// Generic simple dual-port RAM with byte enables and registered read.
`timescale 1ns / 1ps
module cmrt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [WIDTH/8-1:0] wbe,
	input  logic [WIDTH-1:0]   wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [WIDTH-1:0]   rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			for (int b = 0; b < WIDTH / 8; b++) begin
				if (wbe[b]) begin
					mem[waddr][b*8 +: 8] <= wdata[b*8 +: 8];
				end
			end
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/cmrt_div.sv -----
// Restoring radix-2 divider for the percent query, one quotient bit per cycle.
`timescale 1ns / 1ps
module cmrt_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [13:0] dividend,
	input  logic [6:0]  divisor,
	output logic        done,
	output logic [13:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [6:0]  rem_q;
	logic [6:0]  den_q;
	logic [13:0] quo_q;
	logic [7:0]  trial;
	logic        qbit;

	assign trial = {rem_q, quo_q[13]};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd13) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= qbit ? 7'(trial - {1'b0, den_q}) : trial[6:0];
			quo_q <= {quo_q[12:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/core/chunked_message_reassembly_table_core.sv -----
// Top level: slot table, beat writer, percent query and drain sequencer.
//
// channel | direction | handshake          | beat contents
// in      | input     | in_valid/in_stall  | command, msg_id, chunk header, beat_data, beat_last
// out     | output    | out_valid/out_stall| status, result_id, percent_done, message_length,
//         |           |                    | payload_word, run_last
//
// A data beat whose bytes straddle two payload words writes the second word from S_WR2 (RAM write port).
// A percent query is answered directly, or from S_DIV when the divider runs (one quotient bit per cycle).
// A drain steps through S_DRD and S_DWR for each payload word (next read waits in S_DRD for take).
// Reset clears slot valid bits and beat state; payload RAM contents are not cleared.
// in_stall is high while an item is in flight or a result is held by out_stall.
`timescale 1ns / 1ps
module chunked_message_reassembly_table_core #(
	parameter int TABLE_SLOTS = cmrt_pkg::TABLE_SLOTS_DEF,
	parameter int MAX_CHUNKS  = cmrt_pkg::MAX_CHUNKS_DEF,
	parameter int MAX_BYTES   = cmrt_pkg::MAX_BYTES_DEF,
	parameter int BEAT_BYTES  = cmrt_pkg::BEAT_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [15:0] msg_id,
	input  logic [6:0]  chunk_total,
	input  logic [9:0]  byte_total,
	input  logic [5:0]  chunk_number,
	input  logic [9:0]  chunk_offset,
	input  logic [9:0]  chunk_bytes,
	input  logic [63:0] beat_data,
	input  logic        beat_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic [15:0] result_id,
	output logic [6:0]  percent_done,
	output logic [9:0]  message_length,
	output logic [63:0] payload_word,
	output logic        run_last
);

	localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int WPS         = (MAX_BYTES + cmrt_pkg::WORD_BYTES - 1) / cmrt_pkg::WORD_BYTES;
	localparam int STORE_WORDS = TABLE_SLOTS * WPS;
	localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int WB          = cmrt_pkg::WORD_BYTES;
	localparam int WW          = cmrt_pkg::WORD_W;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_WR2  = 5'b00010,
		S_DIV  = 5'b00100,
		S_DRD  = 5'b01000,
		S_DWR  = 5'b10000
	} state_t;

	state_t state_q;

	// slot table
	logic [TABLE_SLOTS-1:0] valid_q;
	logic [15:0]            id_q  [TABLE_SLOTS];
	logic [6:0]             tot_q [TABLE_SLOTS];
	logic [6:0]             cnt_q [TABLE_SLOTS];
	logic [63:0]            map_q [TABLE_SLOTS];
	logic [9:0]             bt_q  [TABLE_SLOTS];

	// beat state
	logic [5:0]        pos_q;
	logic [SLOT_W-1:0] cur_slot_q;
	logic              discard_q;

	// output register
	logic        o_valid_q;
	logic [3:0]  o_status_q;
	logic [15:0] o_id_q;
	logic [6:0]  o_pct_q;
	logic [9:0]  o_len_q;
	logic [63:0] o_word_q;
	logic        o_last_q;

	// drain / query context
	logic [SLOT_W-1:0] d_slot_q;
	logic [15:0]       d_id_q;
	logic [9:0]        d_bt_q;
	logic [6:0]        d_nw_q;
	logic [6:0]        d_k_q;

	// second word of a straddling beat
	logic [ADDR_W-1:0] w2_addr_q;
	logic [WB-1:0]     w2_be_q;
	logic [WW-1:0]     w2_data_q;

	logic acc;
	logic take;
	cmrt_pkg::cmd_t cmd;

	assign cmd  = cmrt_pkg::cmd_t'(command);
	assign take = o_valid_q && !out_stall;
	assign acc  = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || (o_valid_q && out_stall);

	// lookups
	logic              hit, free_found, done_found;
	logic [SLOT_W-1:0] hit_idx, free_idx, done_idx;

	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		free_found = 1'b0;
		free_idx = '0;
		done_found = 1'b0;
		done_idx = '0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			if (!hit && valid_q[i] && id_q[i] == msg_id) begin
				hit = 1'b1;
				hit_idx = SLOT_W'(i);
			end
			if (!free_found && !valid_q[i]) begin
				free_found = 1'b1;
				free_idx = SLOT_W'(i);
			end
			if (!done_found && valid_q[i] && cnt_q[i] == tot_q[i]) begin
				done_found = 1'b1;
				done_idx = SLOT_W'(i);
			end
		end
	end

	// first-beat evaluation
	logic [9:0]        bt_clamp;
	logic              fb_full, fb_alloc, fb_set, oob;
	logic [SLOT_W-1:0] fb_slot;
	logic [6:0]        fb_tot;
	logic [63:0]       fb_map;
	logic [9:0]        fb_bt;
	cmrt_pkg::status_t fb_st;

	assign bt_clamp = (32'(byte_total) > MAX_BYTES) ? 10'(MAX_BYTES) : byte_total;

	always_comb begin
		fb_full  = 1'b0;
		fb_alloc = 1'b0;
		fb_slot  = hit_idx;
		fb_tot   = tot_q[hit_idx];
		fb_map   = map_q[hit_idx];
		fb_bt    = bt_q[hit_idx];
		if (!hit) begin
			if (free_found) begin
				fb_alloc = 1'b1;
				fb_slot  = free_idx;
				fb_tot   = chunk_total;
				fb_map   = '0;
				fb_bt    = bt_clamp;
			end else begin
				fb_full = 1'b1;
			end
		end
		oob = (chunk_offset > fb_bt) || (chunk_bytes > 10'(fb_bt - chunk_offset));
		priority if (fb_full) begin
			fb_st = cmrt_pkg::ST_FULL;
		end else if (7'(chunk_number) >= fb_tot || 32'(chunk_number) >= MAX_CHUNKS) begin
			fb_st = cmrt_pkg::ST_BAD;
		end else if (fb_map[chunk_number]) begin
			fb_st = cmrt_pkg::ST_DUP;
		end else if (oob) begin
			fb_st = cmrt_pkg::ST_OOB;
		end else begin
			fb_st = cmrt_pkg::ST_OK;
		end
		fb_set = (fb_st == cmrt_pkg::ST_OK) || (fb_st == cmrt_pkg::ST_OOB);
	end

	// beat byte placement
	logic              first;
	logic [SLOT_W-1:0] w_slot;
	logic              w_keep;
	logic [9:0]        w_bt;
	logic [6:0]        cnt_base;
	logic [10:0]       base;
	logic [2:0]        shift;
	logic [7:0]        word0;
	logic [127:0]      win_data;
	logic [2*WB-1:0]   be;
	logic [ADDR_W-1:0] addr0, addr1;

	always_comb begin
		int src;
		int kk;
		int dd;
		first  = (pos_q == 6'd0);
		w_slot = first ? (fb_full ? cur_slot_q : fb_slot) : cur_slot_q;
		w_keep = first ? (fb_st == cmrt_pkg::ST_OK) : (!discard_q && valid_q[cur_slot_q]);
		w_bt   = first ? fb_bt : bt_q[cur_slot_q];
		cnt_base = (first && fb_alloc) ? 7'd0 : cnt_q[w_slot];
		base   = 11'(chunk_offset) + 11'(32'(pos_q) * BEAT_BYTES);
		shift  = base[2:0];
		word0  = base[10:3];
		win_data = 128'(beat_data) << {shift, 3'b000};
		for (int j = 0; j < 2 * WB; j++) begin
			src = j - 32'(shift);
			kk  = 32'(pos_q) * BEAT_BYTES + src;
			dd  = 32'({word0, 3'b000}) + j;
			be[j] = w_keep && src >= 0 && src < BEAT_BYTES && kk < 32'(chunk_bytes)
				&& dd < 32'(w_bt);
		end
		addr0 = ADDR_W'(32'(w_slot) * WPS + 32'(word0));
		addr1 = ADDR_W'(32'(w_slot) * WPS + 32'(word0) + 1);
	end

	// divider
	logic        div_start, div_done;
	logic [13:0] div_q;

	assign div_start = acc && cmd == cmrt_pkg::CMD_QUERY && hit
		&& cnt_q[hit_idx] != tot_q[hit_idx] && tot_q[hit_idx] != 7'd0;

	cmrt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (14'(cnt_q[hit_idx]) * 14'd100),
		.divisor  (tot_q[hit_idx]),
		.done     (div_done),
		.quotient (div_q)
	);

	// payload RAM
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [WB-1:0]     ram_be;
	logic [WW-1:0]     ram_wdata, ram_rdata;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr0;
		ram_be    = be[WB-1:0];
		ram_wdata = win_data[WW-1:0];
		if (state_q == S_WR2) begin
			ram_we    = 1'b1;
			ram_waddr = w2_addr_q;
			ram_be    = w2_be_q;
			ram_wdata = w2_data_q;
		end else if (acc && cmd == cmrt_pkg::CMD_BEAT && (|be[WB-1:0])) begin
			ram_we = 1'b1;
		end
	end

	assign ram_re    = (state_q == S_DRD) && !o_valid_q;
	assign ram_raddr = ADDR_W'(32'(d_slot_q) * WPS + 32'(d_k_q));

	cmrt_ram #(
		.WIDTH (WW),
		.DEPTH (STORE_WORDS),
		.AW    (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wbe   (ram_be),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// drain word masking
	logic [10:0] rem;
	logic [63:0] d_word;
	logic        d_last;
	logic [7:0]  nw_full;
	logic [6:0]  nw_cap;

	always_comb begin
		rem = 11'(d_bt_q) - 11'({d_k_q, 3'b000});
		for (int b = 0; b < WB; b++) begin
			d_word[b*8 +: 8] = (rem >= 11'(WB) || 11'(b) < rem) ? ram_rdata[b*8 +: 8] : 8'd0;
		end
		d_last  = (d_k_q == d_nw_q - 7'd1);
		nw_full = 8'((11'(bt_q[done_idx]) + 11'(WB - 1)) >> 3);
		nw_cap  = (32'(nw_full) > cmrt_pkg::RESULT_CAP) ? 7'(cmrt_pkg::RESULT_CAP)
			: nw_full[6:0];
	end

	// output load
	logic        o_ld;
	logic [3:0]  o_st;
	logic [15:0] o_id;
	logic [6:0]  o_pct;
	logic [9:0]  o_len;
	logic [63:0] o_word;
	logic        o_last;

	always_comb begin
		o_ld   = 1'b0;
		o_st   = cmrt_pkg::ST_OK;
		o_id   = '0;
		o_pct  = '0;
		o_len  = '0;
		o_word = '0;
		o_last = 1'b1;
		if (state_q == S_DIV) begin
			if (div_done) begin
				o_ld  = 1'b1;
				o_st  = cmrt_pkg::ST_PERCENT;
				o_id  = d_id_q;
				o_pct = (32'(div_q) > cmrt_pkg::PCT_MAX) ? 7'(cmrt_pkg::PCT_MAX) : div_q[6:0];
			end
		end else if (state_q == S_DWR) begin
			o_ld   = 1'b1;
			o_st   = cmrt_pkg::ST_DATA;
			o_id   = d_id_q;
			o_pct  = 7'(cmrt_pkg::PCT_FULL);
			o_len  = d_bt_q;
			o_word = d_word;
			o_last = d_last;
		end else if (acc) begin
			unique case (cmd)
				cmrt_pkg::CMD_BEAT: begin
					o_ld = first;
					o_st = fb_st;
					o_id = msg_id;
				end
				cmrt_pkg::CMD_QUERY: begin
					o_ld = !div_start;
					o_st = cmrt_pkg::ST_PERCENT;
					o_id = msg_id;
					o_pct = (hit && cnt_q[hit_idx] == tot_q[hit_idx])
						? 7'(cmrt_pkg::PCT_FULL) : 7'd0;
				end
				cmrt_pkg::CMD_DRAIN: begin
					if (!done_found) begin
						o_ld = 1'b1;
						o_st = cmrt_pkg::ST_NONE;
					end else if (bt_q[done_idx] == 10'd0) begin
						o_ld  = 1'b1;
						o_st  = cmrt_pkg::ST_DATA;
						o_id  = id_q[done_idx];
						o_pct = 7'(cmrt_pkg::PCT_FULL);
					end
				end
				cmrt_pkg::CMD_CLEAR: begin
					o_ld = 1'b1;
					o_st = cmrt_pkg::ST_CLEARED;
				end
				default: begin
					o_ld = 1'b0;
				end
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			valid_q    <= '0;
			pos_q      <= '0;
			cur_slot_q <= '0;
			discard_q  <= 1'b0;
			o_valid_q  <= 1'b0;
		end else begin
			if (o_ld) begin
				o_valid_q <= 1'b1;
			end else if (take) begin
				o_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						unique case (cmd)
							cmrt_pkg::CMD_BEAT: begin
								if (first) begin
									if (fb_full) begin
										discard_q <= 1'b1;
									end else begin
										valid_q[fb_slot] <= 1'b1;
										cur_slot_q <= fb_slot;
										discard_q <= (fb_st != cmrt_pkg::ST_OK);
									end
								end
								if (beat_last) begin
									pos_q <= '0;
								end else if (pos_q != 6'd63) begin
									pos_q <= pos_q + 6'd1;
								end
								if (|be[2*WB-1:WB]) begin
									state_q <= S_WR2;
								end
							end
							cmrt_pkg::CMD_QUERY: begin
								if (div_start) begin
									state_q <= S_DIV;
								end
							end
							cmrt_pkg::CMD_DRAIN: begin
								if (done_found) begin
									if (bt_q[done_idx] == 10'd0) begin
										valid_q[done_idx] <= 1'b0;
									end else begin
										state_q <= S_DRD;
									end
								end
							end
							cmrt_pkg::CMD_CLEAR: begin
								valid_q    <= '0;
								pos_q      <= '0;
								cur_slot_q <= '0;
								discard_q  <= 1'b0;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_WR2: begin
					state_q <= S_IDLE;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_IDLE;
					end
				end
				S_DRD: begin
					if (ram_re) begin
						state_q <= S_DWR;
					end
				end
				S_DWR: begin
					if (d_last) begin
						valid_q[d_slot_q] <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DRD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// slot metadata, context and output payload
	always_ff @(posedge clk) begin
		if (acc && cmd == cmrt_pkg::CMD_BEAT) begin
			if (first && !fb_full) begin
				if (fb_alloc) begin
					id_q[fb_slot]  <= msg_id;
					tot_q[fb_slot] <= chunk_total;
					bt_q[fb_slot]  <= bt_clamp;
				end
				map_q[fb_slot] <= fb_set ? (fb_map | (64'd1 << chunk_number)) : fb_map;
			end
			if (first && fb_alloc) begin
				cnt_q[fb_slot] <= (beat_last && w_keep) ? 7'd1 : 7'd0;
			end else if (beat_last && w_keep && 32'(cnt_base) < cmrt_pkg::CNT_MAX) begin
				cnt_q[w_slot] <= cnt_base + 7'd1;
			end
			w2_addr_q <= addr1;
			w2_be_q   <= be[2*WB-1:WB];
			w2_data_q <= win_data[2*WW-1:WW];
		end
		if (acc && cmd == cmrt_pkg::CMD_QUERY) begin
			d_id_q <= msg_id;
		end
		if (acc && cmd == cmrt_pkg::CMD_DRAIN) begin
			d_slot_q <= done_idx;
			d_id_q   <= id_q[done_idx];
			d_bt_q   <= bt_q[done_idx];
			d_nw_q   <= nw_cap;
			d_k_q    <= '0;
		end
		if (state_q == S_DWR) begin
			d_k_q <= d_k_q + 7'd1;
		end
		if (o_ld) begin
			o_status_q <= o_st;
			o_id_q     <= o_id;
			o_pct_q    <= o_pct;
			o_len_q    <= o_len;
			o_word_q   <= o_word;
			o_last_q   <= o_last;
		end
	end

	assign out_valid      = o_valid_q;
	assign status         = o_status_q;
	assign result_id      = o_id_q;
	assign percent_done   = o_pct_q;
	assign message_length = o_len_q;
	assign payload_word   = o_word_q;
	assign run_last       = o_last_q;

endmodule
